// ===== rtl/core/ptt_pkg.sv =====
// Shared types and constants for the periodic task timer table.
package ptt_pkg;

  // Command codes carried in the cmd field of a request.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Table read address selects.
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_LAST = 2'd2;

  // Table write selects.
  localparam logic [1:0] WR_ADD  = 2'd0;
  localparam logic [1:0] WR_MOVE = 2'd1;
  localparam logic [1:0] WR_SET  = 2'd2;
  localparam logic [1:0] WR_FIRE = 2'd3;

  // Result register load selects.
  localparam logic [1:0] OUT_CMD   = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_TICK  = 2'd2;

  localparam int unsigned TIME_W = 48;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       task_id;
    logic [31:0]       period;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [15:0]       task_id_out;
    logic              fired;
    logic [1:0]        status;
    logic [TIME_W-1:0] next_wait;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [15:0]       id;
    logic [31:0]       period;
    logic [TIME_W-1:0] last_fire;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_ld;
    logic       idx_clr;
    logic       idx_inc;
    logic [1:0] rd_sel;
    logic       slot_ld;
    logic       ent_ld;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       best_init;
    logic       stat_ld;
    logic [1:0] stat_val;
    logic       out_ld;
    logic [1:0] out_sel;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] new_cmd;
    logic [1:0] cur_cmd;
    logic       match;
    logic       idx_end;
    logic       idx_last;
    logic       cnt_zero;
    logic       full;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/core/ptt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ptt_dp.sv =====
// Datapath of the periodic task timer table: table memory, counters and result register.
module ptt_dp #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  ptt_pkg::req_t req,
  input  ptt_pkg::ctl_t ctl,
  output ptt_pkg::stat_t st,
  input  logic          rsp_ready,
  output logic          rsp_valid,
  output ptt_pkg::rsp_t rsp
);
  import ptt_pkg::*;

  localparam int unsigned AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam int unsigned EW    = $bits(entry_t);

  req_t              cur;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [AW-1:0]     slot;
  entry_t            ent;
  logic [TIME_W-1:0] elapsed;
  logic              fire;
  logic [TIME_W-1:0] best;
  logic [1:0]        stat;

  logic [CNT_W-1:0]  idx_plus;
  logic [CNT_W-1:0]  cnt_minus;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic              we;
  logic [EW-1:0]     rdata_raw;
  entry_t            rdata;
  logic [TIME_W-1:0] elapsed_next;
  logic [31:0]       left;
  logic [TIME_W-1:0] best_next;

  assign idx_plus  = idx + CNT_W'(1);
  assign cnt_minus = count - CNT_W'(1);
  assign rdata     = entry_t'(rdata_raw);

  always_comb begin
    unique case (ctl.rd_sel)
      RD_NEXT: raddr = idx_plus[AW-1:0];
      RD_LAST: raddr = cnt_minus[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    we = ctl.wr_en;
    unique case (ctl.wr_sel)
      WR_ADD: begin
        waddr = count[AW-1:0];
        wdata = '{id: cur.task_id, period: cur.period, last_fire: '0};
      end
      WR_MOVE: begin
        waddr = slot;
        wdata = rdata;
      end
      WR_SET: begin
        waddr = slot;
        wdata = '{id: ent.id, period: cur.period, last_fire: ent.last_fire};
      end
      default: begin
        waddr = idx[AW-1:0];
        wdata = '{id: ent.id, period: ent.period, last_fire: cur.now};
        we    = ctl.wr_en & fire;
      end
    endcase
  end

  ptt_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_TASKS),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  // Elapsed time wraps at the width of the time base.
  assign elapsed_next = cur.now - rdata.last_fire;

  // An entry that has not fired has elapsed below its period, so the
  // difference fits the period width.
  assign left      = fire ? ent.period : (ent.period - elapsed[31:0]);
  assign best_next = ({{(TIME_W-32){1'b0}}, left} < best) ?
                     {{(TIME_W-32){1'b0}}, left} : best;

  always_ff @(posedge clk) begin
    if (ctl.in_ld) begin
      cur <= req;
    end
    if (ctl.slot_ld) begin
      slot <= idx[AW-1:0];
    end
    if (ctl.ent_ld) begin
      ent     <= rdata;
      elapsed <= elapsed_next;
      fire    <= elapsed_next >= {{(TIME_W-32){1'b0}}, rdata.period};
    end
    if (ctl.stat_ld) begin
      stat <= ctl.stat_val;
    end
    if (ctl.best_init) begin
      best <= '1;
    end else if (ctl.out_ld && ctl.out_sel == OUT_TICK) begin
      best <= best_next;
    end
    if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx_plus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      count <= cnt_minus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_ld) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      unique case (ctl.out_sel)
        OUT_TICK: begin
          rsp.task_id_out <= ent.id;
          rsp.fired       <= fire;
          rsp.status      <= ST_DONE;
          rsp.next_wait   <= (idx_plus == count) ? best_next : '0;
          rsp.last        <= idx_plus == count;
        end
        OUT_EMPTY: begin
          rsp.task_id_out <= '0;
          rsp.fired       <= 1'b0;
          rsp.status      <= ST_DONE;
          rsp.next_wait   <= '1;
          rsp.last        <= 1'b1;
        end
        default: begin
          rsp.task_id_out <= cur.task_id;
          rsp.fired       <= 1'b0;
          rsp.status      <= stat;
          rsp.next_wait   <= '0;
          rsp.last        <= 1'b1;
        end
      endcase
    end
  end

  assign st.new_cmd  = req.cmd;
  assign st.cur_cmd  = cur.cmd;
  assign st.match    = rdata.id == cur.task_id;
  assign st.idx_end  = idx == count;
  assign st.idx_last = idx_plus == count;
  assign st.cnt_zero = count == '0;
  assign st.full     = count == CNT_W'(MAX_TASKS);
  assign st.out_free = ~rsp_valid | rsp_ready;

endmodule

// ===== rtl/core/ptt_ctrl.sv =====
// Controller state machine of the periodic task timer table.
module ptt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ptt_pkg::stat_t st,
  output ptt_pkg::ctl_t  ctl
);
  import ptt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SR_RD  = 4'd1;
  localparam logic [3:0] S_SR_CHK = 4'd2;
  localparam logic [3:0] S_RM_RD  = 4'd3;
  localparam logic [3:0] S_RM_WR  = 4'd4;
  localparam logic [3:0] S_SET_WR = 4'd5;
  localparam logic [3:0] S_RESP   = 4'd6;
  localparam logic [3:0] S_EMPTY  = 4'd7;
  localparam logic [3:0] S_TK_RD  = 4'd8;
  localparam logic [3:0] S_TK_EV  = 4'd9;
  localparam logic [3:0] S_TK_OUT = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = state == S_IDLE;

  always_comb begin
    ctl        = '0;
    ctl.rd_sel = RD_IDX;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.in_ld     = 1'b1;
          ctl.idx_clr   = 1'b1;
          ctl.best_init = 1'b1;
          if (st.new_cmd == CMD_TICK) begin
            state_next = st.cnt_zero ? S_EMPTY : S_TK_RD;
          end else begin
            state_next = S_SR_RD;
          end
        end
      end
      S_SR_RD: begin
        if (st.idx_end) begin
          ctl.stat_ld = 1'b1;
          state_next  = S_RESP;
          if (st.cur_cmd == CMD_ADD) begin
            if (st.full) begin
              ctl.stat_val = ST_FULL;
            end else begin
              ctl.wr_en    = 1'b1;
              ctl.wr_sel   = WR_ADD;
              ctl.cnt_inc  = 1'b1;
              ctl.stat_val = ST_DONE;
            end
          end else begin
            ctl.stat_val = ST_CONFLICT;
          end
        end else begin
          state_next = S_SR_CHK;
        end
      end
      S_SR_CHK: begin
        if (st.match) begin
          ctl.slot_ld = 1'b1;
          ctl.ent_ld  = 1'b1;
          unique case (st.cur_cmd)
            CMD_ADD: begin
              ctl.stat_ld  = 1'b1;
              ctl.stat_val = ST_CONFLICT;
              state_next   = S_RESP;
            end
            CMD_REMOVE: state_next = S_RM_RD;
            default:    state_next = S_SET_WR;
          endcase
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_SR_RD;
        end
      end
      S_RM_RD: begin
        ctl.rd_sel = RD_LAST;
        state_next = S_RM_WR;
      end
      S_RM_WR: begin
        ctl.wr_en    = 1'b1;
        ctl.wr_sel   = WR_MOVE;
        ctl.cnt_dec  = 1'b1;
        ctl.stat_ld  = 1'b1;
        ctl.stat_val = ST_DONE;
        state_next   = S_RESP;
      end
      S_SET_WR: begin
        ctl.wr_en    = 1'b1;
        ctl.wr_sel   = WR_SET;
        ctl.stat_ld  = 1'b1;
        ctl.stat_val = ST_DONE;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          ctl.out_ld  = 1'b1;
          ctl.out_sel = OUT_CMD;
          state_next  = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          ctl.out_ld  = 1'b1;
          ctl.out_sel = OUT_EMPTY;
          state_next  = S_IDLE;
        end
      end
      S_TK_RD: begin
        state_next = S_TK_EV;
      end
      S_TK_EV: begin
        ctl.ent_ld = 1'b1;
        state_next = S_TK_OUT;
      end
      S_TK_OUT: begin
        // The next entry is read while this one is written back.
        ctl.rd_sel = RD_NEXT;
        if (st.out_free) begin
          ctl.out_ld  = 1'b1;
          ctl.out_sel = OUT_TICK;
          ctl.wr_en   = 1'b1;
          ctl.wr_sel  = WR_FIRE;
          ctl.idx_inc = 1'b1;
          state_next  = st.idx_last ? S_IDLE : S_TK_EV;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table.
//
// This block keeps a compact table of up to MAX_TASKS periodic tasks, each
// holding an id, a period and a last-fire time, in one RAM with a registered
// read port. A request transaction carries add, remove, set-period or tick.
// Add, remove and set-period search the table from entry 0, visiting each
// entry in a read state and a check state, then update the table where
// needed and give a single response transaction. A tick gives one response
// per entry in table order, each entry passing through an evaluate state and
// an output state that waits while the response side stalls; the registered
// table read is followed by the elapsed-time subtract and compare. An entry
// fires when the time since its last firing, taken modulo 2^48, reaches its
// period, and its last-fire time is then written back as the tick time. The
// final response of a tick carries the smallest time until any entry fires
// next, or all ones if the table is empty. The block accepts one request at
// a time; a finished response waits in the output register while the next
// request is accepted.
module periodic_task_timer_table #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ptt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ptt_pkg::rsp_t rsp
);
  import ptt_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  ctl_t  ctl;
  stat_t st;

  // The controller walks each request through search, update and response.
  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .st       (st),
    .ctl      (ctl)
  );

  // The datapath holds the table, the entry count and the response register.
  ptt_dp #(
    .MAX_TASKS(MAX_TASKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ctl      (ctl),
    .st       (st),
    .rsp_ready(rsp_ready),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

endmodule
